// ===== hw/rtl/wats_pkg.sv =====
// Shared types and constants for the weighted ATR trailing stop block.
`timescale 1ns / 1ps

package wats_pkg;

    localparam int PERIOD_W = 7;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 7'd14;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_READ    = 7'b0000010,
        S_DIV     = 7'b0000100,
        S_TRAIL_A = 7'b0001000,
        S_TRAIL_B = 7'b0010000,
        S_EMIT    = 7'b0100000,
        S_WRITE   = 7'b1000000
    } state_t;

    typedef struct packed {
        logic step_a;
        logic step_b;
        logic first_bar;
        logic trend_up;
    } trail_ctl_t;

endpackage

// ===== hw/rtl/wats_bar_if.sv =====
// Price bar channel: valid/ready handshake with open, high, low and close.
`timescale 1ns / 1ps

interface wats_bar_if #(
    parameter int PRICE_WIDTH = 32
);
    logic                   valid;
    logic                   ready;
    logic [PRICE_WIDTH-1:0] open_price;
    logic [PRICE_WIDTH-1:0] high_price;
    logic [PRICE_WIDTH-1:0] low_price;
    logic [PRICE_WIDTH-1:0] close_price;

    modport source (output valid, output open_price, output high_price,
                    output low_price, output close_price, input ready);
    modport sink (input valid, input open_price, input high_price,
                  input low_price, input close_price, output ready);
endinterface

// ===== hw/rtl/wats_res_if.sv =====
// Result channel: valid/ready handshake with trend, extreme, stop and range.
`timescale 1ns / 1ps

interface wats_res_if #(
    parameter int PRICE_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic                          trend_up;
    logic [PRICE_WIDTH-1:0]        extreme_price;
    logic signed [PRICE_WIDTH+2:0] stop_level;
    logic [PRICE_WIDTH:0]          weighted_range;

    modport source (output valid, output trend_up, output extreme_price,
                    output stop_level, output weighted_range, input ready);
    modport sink (input valid, input trend_up, input extreme_price,
                  input stop_level, input weighted_range, output ready);
endinterface

// ===== hw/rtl/wats_cfg_if.sv =====
// Configuration write channel carrying the period length.
`timescale 1ns / 1ps

interface wats_cfg_if;
    import wats_pkg::*;

    logic                valid;
    logic                ready;
    logic [PERIOD_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/wats_ring_mem.sv =====
// Range history memory, one write port and one registered read port.
`timescale 1ns / 1ps

module wats_ring_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== hw/rtl/wats_divider.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module wats_divider #(
    parameter int QW = 33,
    parameter int DW = 13
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [QW+DW-1:0] dividend,
    input  logic [DW-1:0]    divisor,
    output logic             done,
    output logic [QW-1:0]    quotient
);
    localparam int CNTW = $clog2(QW + 1);

    logic [DW-1:0]   rem_reg, rem_next;
    logic [QW-1:0]   quo_reg, quo_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            done_reg, done_next;
    logic [DW:0]     shifted;
    logic [DW:0]     diff;
    logic            fits;

    // dividend >> QW is below the divisor, so QW steps give the full quotient
    assign shifted = {rem_reg, quo_reg[QW-1]};
    assign diff    = shifted - {1'b0, divisor};
    assign fits    = shifted >= {1'b0, divisor};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = dividend[QW+DW-1:QW];
            quo_next = dividend[QW-1:0];
            cnt_next = CNTW'(QW);
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = fits ? diff[DW-1:0] : shifted[DW-1:0];
            quo_next  = {quo_reg[QW-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNTW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

// ===== hw/rtl/wats_trail.sv =====
// Trailing stop update in two registered steps: extreme/stop, then flip check.
`timescale 1ns / 1ps

module wats_trail #(
    parameter int PW = 32
) (
    input  logic                        clk,
    input  wats_pkg::trail_ctl_t        ctl,
    input  logic [PW-1:0]               extreme,
    input  logic [PW-1:0]               open_p,
    input  logic [PW-1:0]               close_p,
    input  logic [PW:0]                 wrange,
    output logic                        up,
    output logic [PW-1:0]               price,
    output logic signed [PW+2:0]        stop
);
    import wats_pkg::*;

    localparam int SIW = PW + 3;

    logic signed [SIW-1:0] sc, so, wr, ext;
    logic signed [SIW-1:0] a_price_reg, a_price_next;
    logic signed [SIW-1:0] a_stop_reg, a_stop_next;
    logic                  a_up_reg, a_up_next;
    logic                  a_first_reg;
    logic signed [SIW-1:0] b_price_reg, b_price_next;
    logic signed [SIW-1:0] b_stop_reg, b_stop_next;
    logic                  b_up_reg, b_up_next;

    assign sc  = signed'({3'b000, close_p});
    assign so  = signed'({3'b000, open_p});
    assign ext = signed'({3'b000, extreme});
    assign wr  = signed'({2'b00, wrange});

    always_comb
    begin
        if (ctl.first_bar)
        begin
            a_price_next = sc;
            a_up_next    = (close_p >= open_p);
            a_stop_next  = a_up_next ? sc - wr : sc + wr;
        end
        else if (ctl.trend_up)
        begin
            a_price_next = (sc > ext) ? sc : ext;
            a_up_next    = 1'b1;
            a_stop_next  = a_price_next - wr;
        end
        else
        begin
            a_price_next = (sc < ext) ? sc : ext;
            a_up_next    = 1'b0;
            a_stop_next  = a_price_next + wr;
        end
    end

    always_comb
    begin
        b_price_next = a_price_reg;
        b_stop_next  = a_stop_reg;
        b_up_next    = a_up_reg;
        if (!a_first_reg)
        begin
            if (a_up_reg)
            begin
                if ((so < a_stop_reg || sc <= so) && sc < a_stop_reg)
                begin
                    b_price_next = sc;
                    b_stop_next  = sc + wr;
                    b_up_next    = 1'b0;
                end
            end
            else
            begin
                if ((so > a_stop_reg || sc >= so) && sc > a_stop_reg)
                begin
                    b_price_next = sc;
                    b_stop_next  = sc - wr;
                    b_up_next    = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.step_a)
        begin
            a_price_reg <= a_price_next;
            a_stop_reg  <= a_stop_next;
            a_up_reg    <= a_up_next;
            a_first_reg <= ctl.first_bar;
        end
        if (ctl.step_b)
        begin
            b_price_reg <= b_price_next;
            b_stop_reg  <= b_stop_next;
            b_up_reg    <= b_up_next;
        end
    end

    assign up    = b_up_reg;
    assign price = b_price_reg[PW-1:0];
    assign stop  = b_stop_reg;
endmodule

// ===== hw/rtl/weighted_atr_trailing_stop.sv =====
// Top level: weighted ATR trailing stop with range history memory.
// One bar at a time. A bar that yields a result goes through N reads of the range memory and
// PRICE_WIDTH + 1 divider steps, then the trail update; the next bar is taken only once the
// result has entered the output register, so an output stall holds the block.
// Warm-up bars yield no result and only update the range history. A finished result waits in an output register.
// Reset (rst_n low, async) clears control, trend, extreme, history count; period = 14.
`timescale 1ns / 1ps

module weighted_atr_trailing_stop #(
    parameter int MAX_PERIOD  = 64,
    parameter int PRICE_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    wats_bar_if.sink   bar,
    wats_res_if.source result,
    wats_cfg_if.sink   cfg
);
    import wats_pkg::*;

    localparam int PW   = PRICE_WIDTH;
    localparam int QW   = PW + 1;
    localparam int AW   = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
    localparam int NW   = $clog2(MAX_PERIOD + 1);
    localparam int SEW  = $clog2(MAX_PERIOD + 2);
    localparam int WW   = $clog2(2 * MAX_PERIOD);
    localparam int DW   = $clog2(MAX_PERIOD * MAX_PERIOD + 1);
    localparam int SW   = QW + DW;
    localparam int PRW  = PW + WW;
    localparam logic [AW-1:0]  LAST_SLOT = AW'(MAX_PERIOD - 1);
    localparam logic [SEW-1:0] SEEN_MAX  = SEW'(MAX_PERIOD + 1);

    state_t state_reg, state_next;

    logic [PERIOD_W-1:0] period_reg;
    logic [AW-1:0]       head_reg;
    logic [SEW-1:0]      seen_reg;
    logic                trend_reg;
    logic [PW-1:0]       extreme_reg;

    logic [PW-1:0]       open_reg, close_reg, range_reg;
    logic                first_reg;
    logic [NW-1:0]       n_eff;
    logic [DW-1:0]       n_sq_reg;
    logic [2*NW-1:0]     n_sq_full;
    logic [NW-1:0]       left_reg;
    logic [AW-1:0]       ptr_reg;
    logic [WW-1:0]       weight_reg;
    logic [WW-1:0]       weight_d_reg;
    logic [WW:0]         weight_init;
    logic                rd_v_reg;
    logic                prod_v_reg;
    logic [PRW-1:0]      prod_reg;
    logic [SW-1:0]       acc_reg;

    logic                res_valid_reg;
    logic                res_up_reg;
    logic [PW-1:0]       res_ext_reg;
    logic signed [PW+2:0] res_stop_reg;
    logic [QW-1:0]       res_wr_reg;

    logic                bar_take;
    logic                issue;
    logic                read_done;
    logic                emit_load;
    logic [PW-1:0]       bar_range;
    logic [PW-1:0]       mem_rdata;
    logic                div_done;
    logic [QW-1:0]       wr_value;
    trail_ctl_t          trail_ctl;
    logic                tr_up;
    logic [PW-1:0]       tr_price;
    logic signed [PW+2:0] tr_stop;

    function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] s);
        return (s == '0) ? LAST_SLOT : s - 1'b1;
    endfunction

    always_comb
    begin
        if (period_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (int'(period_reg) > MAX_PERIOD)
        begin
            n_eff = NW'(MAX_PERIOD);
        end
        else
        begin
            n_eff = NW'(period_reg);
        end
    end

    assign n_sq_full   = {{NW{1'b0}}, n_eff} * {{NW{1'b0}}, n_eff};
    assign weight_init = ((WW+1)'(n_eff) << 1) - (WW+1)'(1);
    assign bar_range   = (bar.high_price >= bar.low_price) ?
                         bar.high_price - bar.low_price : bar.low_price - bar.high_price;

    assign bar.ready  = (state_reg == S_IDLE);
    assign bar_take   = bar.valid && bar.ready;
    assign cfg.ready  = 1'b1;

    assign issue     = (state_reg == S_READ) && (left_reg != '0);
    assign read_done = (state_reg == S_READ) && (left_reg == '0) && !rd_v_reg && !prod_v_reg;
    assign emit_load = (state_reg == S_EMIT) && (!res_valid_reg || result.ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (bar_take)
                begin
                    state_next = (int'(seen_reg) >= int'(n_eff)) ? S_READ : S_WRITE;
                end
            end
            S_READ:
            begin
                if (read_done)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_TRAIL_A;
                end
            end
            S_TRAIL_A: state_next = S_TRAIL_B;
            S_TRAIL_B: state_next = S_EMIT;
            S_EMIT:
            begin
                if (emit_load)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            period_reg    <= PERIOD_RESET;
            head_reg      <= '0;
            seen_reg      <= '0;
            trend_reg     <= 1'b0;
            extreme_reg   <= '0;
            res_valid_reg <= 1'b0;
            rd_v_reg      <= 1'b0;
            prod_v_reg    <= 1'b0;
            left_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_v_reg   <= issue;
            prod_v_reg <= rd_v_reg;
            if (cfg.valid && cfg.ready)
            begin
                period_reg <= cfg.data;
            end
            if (bar_take)
            begin
                left_reg <= n_eff;
            end
            else if (issue)
            begin
                left_reg <= left_reg - 1'b1;
            end
            if (emit_load)
            begin
                res_valid_reg <= 1'b1;
                trend_reg     <= tr_up;
                extreme_reg   <= tr_price;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            if (state_reg == S_WRITE)
            begin
                head_reg <= (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
                if (seen_reg != SEEN_MAX)
                begin
                    seen_reg <= seen_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (bar_take)
        begin
            open_reg   <= bar.open_price;
            close_reg  <= bar.close_price;
            range_reg  <= bar_range;
            first_reg  <= (int'(seen_reg) == int'(n_eff));
            n_sq_reg   <= n_sq_full[DW-1:0];
            ptr_reg    <= slot_dec(head_reg);
            weight_reg <= weight_init[WW-1:0];
            acc_reg    <= '0;
        end
        else
        begin
            if (issue)
            begin
                ptr_reg    <= slot_dec(ptr_reg);
                weight_reg <= weight_reg - 1'b1;
            end
            if (prod_v_reg)
            begin
                acc_reg <= acc_reg + SW'(prod_reg);
            end
        end
        weight_d_reg <= weight_reg;
        if (rd_v_reg)
        begin
            prod_reg <= mem_rdata * weight_d_reg;
        end
        if (emit_load)
        begin
            res_up_reg   <= tr_up;
            res_ext_reg  <= tr_price;
            res_stop_reg <= tr_stop;
            res_wr_reg   <= wr_value;
        end
    end

    wats_ring_mem #(
        .DEPTH (MAX_PERIOD),
        .WIDTH (PW),
        .AW    (AW)
    ) u_ring (
        .clk   (clk),
        .we    (state_reg == S_WRITE),
        .waddr (head_reg),
        .wdata (range_reg),
        .re    (issue),
        .raddr (ptr_reg),
        .rdata (mem_rdata)
    );

    wats_divider #(
        .QW (QW),
        .DW (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (read_done),
        .dividend (acc_reg),
        .divisor  (n_sq_reg),
        .done     (div_done),
        .quotient (wr_value)
    );

    assign trail_ctl.step_a    = (state_reg == S_TRAIL_A);
    assign trail_ctl.step_b    = (state_reg == S_TRAIL_B);
    assign trail_ctl.first_bar = first_reg;
    assign trail_ctl.trend_up  = trend_reg;

    wats_trail #(
        .PW (PW)
    ) u_trail (
        .clk     (clk),
        .ctl     (trail_ctl),
        .extreme (extreme_reg),
        .open_p  (open_reg),
        .close_p (close_reg),
        .wrange  (wr_value),
        .up      (tr_up),
        .price   (tr_price),
        .stop    (tr_stop)
    );

    assign result.valid          = res_valid_reg;
    assign result.trend_up       = res_up_reg;
    assign result.extreme_price  = res_ext_reg;
    assign result.stop_level     = res_stop_reg;
    assign result.weighted_range = res_wr_reg;
endmodule

// ===== hw/rtl/wats_checker.sv =====
// Port-level checks for the weighted ATR trailing stop, bound to the top level.
`timescale 1ns / 1ps

module wats_checker #(
    parameter int PRICE_WIDTH = 32
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          bar_valid,
    input logic                          bar_ready,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic                          trend_up,
    input logic [PRICE_WIDTH-1:0]        extreme_price,
    input logic signed [PRICE_WIDTH+2:0] stop_level,
    input logic [PRICE_WIDTH:0]          weighted_range
);
    logic signed [PRICE_WIDTH+2:0] ext_s;
    logic signed [PRICE_WIDTH+2:0] wr_s;
    logic signed [PRICE_WIDTH+2:0] expect_stop;

    assign ext_s       = signed'({3'b000, extreme_price});
    assign wr_s        = signed'({2'b00, weighted_range});
    assign expect_stop = trend_up ? ext_s - wr_s : ext_s + wr_s;

    // stop sits one weighted range behind the extreme on the trend side
    a_stop_offset: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> stop_level == expect_stop)
        else $error("stop_level not extreme -/+ weighted_range");

    // one bar in flight: no transaction on the next cycle after a bar
    a_one_bar: assert property (@(posedge clk) disable iff (!rst_n)
        bar_valid && bar_ready |=> !bar_ready)
        else $error("bar accepted on consecutive cycles");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped before transaction");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(trend_up) && $stable(extreme_price)
            && $stable(stop_level) && $stable(weighted_range))
        else $error("result payload changed while stalled");
endmodule

bind weighted_atr_trailing_stop wats_checker #(
    .PRICE_WIDTH (PRICE_WIDTH)
) u_wats_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .bar_valid      (bar.valid),
    .bar_ready      (bar.ready),
    .res_valid      (result.valid),
    .res_ready      (result.ready),
    .trend_up       (result.trend_up),
    .extreme_price  (result.extreme_price),
    .stop_level     (result.stop_level),
    .weighted_range (result.weighted_range)
);
